[rtl/core/sdf_pkg.sv]
// shared constants, codes and types of the signed distance field block
// no dependencies
package sdf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int AW         = XW + YW;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int LINE_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LW         = $clog2(LINE_DEPTH);

  localparam int GRID_W = 9;
  localparam int CELL_W = 21;
  localparam int CFG_W  = 21;
  localparam int CFG_IW = 2;
  localparam int DIST_W = 32;
  localparam int SQ_W   = 17;
  localparam logic [SQ_W-1:0] SQ_NONE = '1;

  localparam int NUM_W  = ((SQ_W > 2 * LW) ? SQ_W : 2 * LW) + 2;
  localparam int BND_W  = NUM_W + 1;
  localparam int DEN_W  = LW + 1;
  localparam int SUM_W  = ((2 * LW + 3) > (SQ_W + 1)) ? (2 * LW + 3) : (SQ_W + 1);
  localparam int ROOT_W = (SQ_W + 16 + 1) / 2;
  localparam int DIV_ITER = NUM_W - 1;
  localparam int OP_W   = ((2 * ROOT_W) > DIV_ITER) ? (2 * ROOT_W) : DIV_ITER;
  localparam int RES_W  = (ROOT_W > DIV_ITER) ? ROOT_W : DIV_ITER;
  localparam int REM_W  = RES_W + 4;
  localparam int CNT_W  = $clog2(RES_W + 1);
  localparam int PROD_W = CELL_W + ROOT_W;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  localparam logic [CFG_IW-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CELL_SIZE   = 2'd2;

  localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;
  localparam logic [CELL_W-1:0] CELL_RESET = 21'd6554;

  typedef struct packed {
    logic              start;
    logic              op_sqrt;
    logic [OP_W-1:0]   operand;
    logic [DEN_W-1:0]  divisor;
  } iter_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RES_W-1:0]  result;
    logic              rem_nz;
  } iter_rsp_t;

  typedef struct packed {
    logic [LW-1:0]           site;
    logic [SQ_W-1:0]         fval;
    logic signed [BND_W-1:0] bnd;
  } env_entry_t;

endpackage

[rtl/core/sdf_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module sdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/sdf_iter_unit.sv]
// shared shift-subtract unit: restoring divide or digit-by-digit square root
// depends on sdf_pkg
module sdf_iter_unit import sdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic             is_sqrt;
  logic [OP_W-1:0]  sh;
  logic [DEN_W-1:0] div_r;
  logic [REM_W-1:0] rem;
  logic [RES_W-1:0] res;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    rem_sh = is_sqrt ? {rem[REM_W-3:0], sh[OP_W-1 -: 2]} : {rem[REM_W-2:0], sh[OP_W-1]};
    trial  = is_sqrt ? REM_W'({res, 2'b01}) : REM_W'(div_r);
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        is_sqrt <= req.op_sqrt;
        sh      <= req.operand;
        div_r   <= req.divisor;
        rem     <= '0;
        res     <= '0;
        cnt     <= req.op_sqrt ? CNT_W'(ROOT_W) : CNT_W'(DIV_ITER);
      end else if (busy) begin
        sh  <= is_sqrt ? (sh << 2) : (sh << 1);
        rem <= ge ? (rem_sh - trial) : rem_sh;
        res <= {res[RES_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = res;
  assign rsp.rem_nz = |rem;

endmodule

[rtl/core/signed_distance_field_2d.sv]
// top level of the signed distance field: grid stores, envelope sequencer, conversion
// depends on sdf_pkg, sdf_ram, sdf_iter_unit
//
// channel   direction  fields (lowest bit up)
// s_axis    in         tuser: cmd[1:0]; tdata: cell_x[7:0] cell_y[15:8] occupied[16]
// m_axis    out        tdata: signed_distance[31:0] outside_sq[48:32] inside_sq[65:49]
//                      tuser: out_of_map[0] compute_done[1]
// cfg       in         cfg_we, cfg_index, cfg_wdata
//
// clear: sweeps every cell (65536) of the occupancy store
// compute: per line one read per cell plus a division on the shared divider per
//   envelope test, then one write per cell along the envelope walk; the final
//   sweep takes a root on the shared square root unit for each cell in reach
// reset starts the same clearing sweep of all 65536 cells of the occupancy store
// a pending result stalls only the next query or compute and the input behind it
module signed_distance_field_2d import sdf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // cell_x, cell_y, occupied
  input  logic [1:0]             s_tuser,   // cmd
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // signed_distance, outside_sq, inside_sq
  output logic [1:0]             m_tuser,   // out_of_map, compute_done
  input  logic                   cfg_we,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  typedef enum logic [20:0] {
    S_CLEAR = 21'h000001,
    S_IDLE  = 21'h000002,
    S_QRD   = 21'h000004,
    S_EMIT  = 21'h000008,
    S_LINE  = 21'h000010,
    B_RD    = 21'h000020,
    B_CHK   = 21'h000040,
    B_NUM   = 21'h000080,
    B_DIV   = 21'h000100,
    B_POP   = 21'h000200,
    B_POPW  = 21'h000400,
    W_RDK   = 21'h000800,
    W_GETK  = 21'h001000,
    W_GETN  = 21'h002000,
    W_OUT   = 21'h004000,
    W_FILL  = 21'h008000,
    F_RD    = 21'h010000,
    F_CHK   = 21'h020000,
    F_SQRT  = 21'h040000,
    F_MUL   = 21'h080000,
    F_WR    = 21'h100000
  } state_t;

  state_t state;

  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_height;
  logic [CELL_W-1:0] cell_size;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] qaddr;
  logic          q_oob;
  logic          emit_cmp;

  logic          pass_inside;
  logic          pass_row;
  logic [LW-1:0] line_idx;
  logic [LW-1:0] q;
  logic [LW-1:0] top;
  logic          have;
  logic [SQ_W-1:0] freg;
  env_entry_t    cache;
  logic          num_neg;

  logic [LW-1:0]   k;
  logic [LW-1:0]   k_site;
  logic [SQ_W-1:0] k_f;
  env_entry_t      nxt;

  logic [LW-1:0]     fx;
  logic [LW-1:0]     fy;
  logic              occ_r;
  logic [ROOT_W-1:0] root;
  logic [DIST_W-1:0] dist_val;

  logic [LW-1:0] w_m1;
  logic [LW-1:0] h_m1;
  logic [LW-1:0] n_m1;
  logic [LW-1:0] lines_m1;

  logic [7:0] in_x;
  logic [7:0] in_y;
  logic       in_occ;
  logic [AW-1:0] in_addr;
  logic       in_grid;
  logic       acc;
  logic       out_free;

  logic [AW-1:0] line_addr;
  logic [AW-1:0] fin_addr;
  logic [AW-1:0] cell_raddr;

  logic          occ_we;
  logic [AW-1:0] occ_waddr;
  logic          occ_wdata;
  logic [AW-1:0] occ_raddr;
  logic          occ_rdata;
  logic          col_we;
  logic [SQ_W-1:0] col_rdata;
  logic          osq_we;
  logic          isq_we;
  logic [SQ_W-1:0] sq_wdata;
  logic [SQ_W-1:0] osq_rdata;
  logic [SQ_W-1:0] isq_rdata;
  logic          dist_we;
  logic [DIST_W-1:0] dist_rdata;
  logic          env_we;
  logic [LW-1:0] env_waddr;
  env_entry_t    env_wdata;
  logic [LW-1:0] env_raddr;
  env_entry_t    env_rdata;

  iter_req_t req;
  iter_rsp_t rsp;

  logic [SQ_W-1:0]         f_cur;
  logic [2*LW-1:0]         qsq;
  logic [2*LW-1:0]         vsq;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-2:0]        num_mag;
  logic signed [BND_W-1:0] s_val;
  logic signed [BND_W-1:0] q_s;
  logic                    adv;
  logic                    wb;
  logic                    step_q;
  logic signed [LW:0]      wd;
  logic [2*LW+1:0]         wd2;
  logic [SUM_W-1:0]        wsum;
  logic [SQ_W-1:0]         wval;
  logic [SQ_W-1:0]         fin_d2;
  logic [PROD_W-1:0]       prod;
  logic [DIST_W-1:0]       mval;

  // geometry
  always_comb begin
    if (grid_width == '0) begin
      w_m1 = '0;
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_m1 = LW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = LW'(grid_width - GRID_W'(1));
    end
    if (grid_height == '0) begin
      h_m1 = '0;
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_m1 = LW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = LW'(grid_height - GRID_W'(1));
    end
    n_m1     = pass_row ? w_m1 : h_m1;
    lines_m1 = pass_row ? h_m1 : w_m1;
  end

  assign in_x     = s_tdata[7:0];
  assign in_y     = s_tdata[15:8];
  assign in_occ   = s_tdata[16];
  assign in_addr  = {YW'(in_y), XW'(in_x)};
  assign in_grid  = (32'(in_x) <= 32'(w_m1)) && (32'(in_y) <= 32'(h_m1));
  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign line_addr  = pass_row ? {YW'(line_idx), XW'(q)} : {YW'(q), XW'(line_idx)};
  assign fin_addr   = {YW'(fy), XW'(fx)};
  assign cell_raddr = (state inside {S_QRD, S_EMIT}) ? qaddr : fin_addr;
  assign occ_raddr  = (state inside {F_RD, F_CHK, F_SQRT, F_MUL, F_WR}) ? fin_addr : line_addr;

  // envelope build datapath
  always_comb begin
    f_cur   = pass_row ? col_rdata : ((occ_rdata == !pass_inside) ? '0 : SQ_NONE);
    qsq     = q * q;
    vsq     = cache.site * cache.site;
    num     = $signed(NUM_W'(freg)) + $signed(NUM_W'(qsq))
            - $signed(NUM_W'(cache.fval)) - $signed(NUM_W'(vsq));
    num_mag = num[NUM_W-1] ? (NUM_W-1)'(-num) : num[NUM_W-2:0];
    s_val   = num_neg ? (-$signed(BND_W'(rsp.result)) - $signed(BND_W'(rsp.rem_nz)))
                      : $signed(BND_W'(rsp.result));
    q_s     = $signed(BND_W'(q));
  end

  // envelope walk datapath
  always_comb begin
    adv    = (state == W_OUT) && (k < top) && (nxt.bnd < q_s);
    wb     = ((state == W_OUT) && !adv) || (state == W_FILL);
    step_q = wb;
    wd     = $signed({1'b0, q}) - $signed({1'b0, k_site});
    wd2    = (2*LW+2)'(wd * wd);
    wsum   = SUM_W'(wd2) + SUM_W'(k_f);
    wval   = (wsum >= SUM_W'(SQ_NONE)) ? SQ_NONE : SQ_W'(wsum);
    fin_d2 = occ_rdata ? isq_rdata : osq_rdata;
    prod   = PROD_W'(cell_size) * PROD_W'(root);
    mval   = DIST_W'(prod >> 8);
  end

  // store controls
  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = clr_addr;
    occ_wdata = 1'b0;
    if (state == S_CLEAR) begin
      occ_we = 1'b1;
    end else if (acc && (s_tuser == CMD_WRITE) && in_grid) begin
      occ_we    = 1'b1;
      occ_waddr = in_addr;
      occ_wdata = in_occ;
    end
    col_we   = wb && !pass_row;
    osq_we   = wb && pass_row && !pass_inside;
    isq_we   = wb && pass_row && pass_inside;
    sq_wdata = (state == W_FILL) ? SQ_NONE : wval;
    dist_we  = (state == F_WR);

    env_we    = 1'b0;
    env_waddr = '0;
    env_wdata = '{site: q, fval: f_cur, bnd: '0};
    if ((state == B_CHK) && (f_cur != SQ_NONE) && !have) begin
      env_we = 1'b1;
    end else if ((state == B_DIV) && rsp.done && !((top != '0) && (s_val <= cache.bnd))) begin
      env_we    = 1'b1;
      env_waddr = top + LW'(1);
      env_wdata = '{site: q, fval: freg, bnd: s_val};
    end

    case (state)
      B_POP:   env_raddr = top;
      W_GETK:  env_raddr = k + LW'(1);
      W_OUT:   env_raddr = k + LW'(2);
      default: env_raddr = '0;
    endcase

    req.start   = 1'b0;
    req.op_sqrt = 1'b0;
    req.operand = {num_mag, (OP_W - DIV_ITER)'(0)};
    req.divisor = DEN_W'({q - cache.site, 1'b0});
    if (state == B_NUM) begin
      req.start = 1'b1;
    end else if ((state == F_CHK) && (fin_d2 != SQ_NONE)) begin
      req.start   = 1'b1;
      req.op_sqrt = 1'b1;
      req.operand = OP_W'({fin_d2, 16'h0000});
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
      cell_size   <= CELL_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_wdata[GRID_W-1:0];
          REG_GRID_HEIGHT: grid_height <= cfg_wdata[GRID_W-1:0];
          REG_CELL_SIZE:   cell_size   <= cfg_wdata[CELL_W-1:0];
          default: ;
        endcase
      end
      if (m_tready && !((state == S_EMIT) && out_free)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            case (s_tuser)
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              CMD_COMPUTE: begin
                pass_inside <= 1'b0;
                pass_row    <= 1'b0;
                line_idx    <= '0;
                state       <= S_LINE;
              end
              CMD_QUERY: begin
                qaddr    <= in_addr;
                q_oob    <= !in_grid;
                emit_cmp <= 1'b0;
                state    <= S_QRD;
              end
              default: ;
            endcase
          end
        end
        S_QRD: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (emit_cmp) begin
              m_tdata <= '0;
              m_tuser <= 2'b10;
            end else if (q_oob) begin
              m_tdata <= '0;
              m_tuser <= 2'b01;
            end else begin
              m_tdata <= OUT_TDATA_W'({isq_rdata, osq_rdata, dist_rdata});
              m_tuser <= 2'b00;
            end
            state <= S_IDLE;
          end
        end
        S_LINE: begin
          q     <= '0;
          have  <= 1'b0;
          state <= B_RD;
        end
        B_RD: state <= B_CHK;
        B_CHK: begin
          freg <= f_cur;
          if (f_cur == SQ_NONE || !have) begin
            if (f_cur != SQ_NONE) begin
              top   <= '0;
              have  <= 1'b1;
              cache <= '{site: q, fval: f_cur, bnd: '0};
            end
            if (q == n_m1) begin
              state <= W_RDK;
            end else begin
              q     <= q + LW'(1);
              state <= B_RD;
            end
          end else begin
            state <= B_NUM;
          end
        end
        B_NUM: begin
          num_neg <= num[NUM_W-1];
          state   <= B_DIV;
        end
        B_DIV: begin
          if (rsp.done) begin
            if ((top != '0) && (s_val <= cache.bnd)) begin
              top   <= top - LW'(1);
              state <= B_POP;
            end else begin
              top   <= top + LW'(1);
              cache <= '{site: q, fval: freg, bnd: s_val};
              if (q == n_m1) begin
                state <= W_RDK;
              end else begin
                q     <= q + LW'(1);
                state <= B_RD;
              end
            end
          end
        end
        B_POP:  state <= B_POPW;
        B_POPW: begin
          cache <= env_rdata;
          state <= B_NUM;
        end
        W_RDK: begin
          q     <= '0;
          k     <= '0;
          state <= have ? W_GETK : W_FILL;
        end
        W_GETK: begin
          k_site <= env_rdata.site;
          k_f    <= env_rdata.fval;
          state  <= (k < top) ? W_GETN : W_OUT;
        end
        W_GETN: begin
          nxt   <= env_rdata;
          state <= W_OUT;
        end
        W_OUT: begin
          if (adv) begin
            k      <= k + LW'(1);
            k_site <= nxt.site;
            k_f    <= nxt.fval;
            if ((k + LW'(1)) < top) begin
              state <= W_GETN;
            end
          end
        end
        W_FILL: ;
        F_RD: state <= F_CHK;
        F_CHK: begin
          occ_r <= occ_rdata;
          if (fin_d2 == SQ_NONE) begin
            dist_val <= occ_rdata ? 32'h8000_0000 : 32'h7fff_ffff;
            state    <= F_WR;
          end else begin
            state <= F_SQRT;
          end
        end
        F_SQRT: begin
          if (rsp.done) begin
            root  <= rsp.result[ROOT_W-1:0];
            state <= F_MUL;
          end
        end
        F_MUL: begin
          dist_val <= occ_r ? (DIST_W'(cell_size) - mval) : mval;
          state    <= F_WR;
        end
        F_WR: begin
          if (fx == w_m1) begin
            fx <= '0;
            if (fy == h_m1) begin
              emit_cmp <= 1'b1;
              state    <= S_EMIT;
            end else begin
              fy    <= fy + LW'(1);
              state <= F_RD;
            end
          end else begin
            fx    <= fx + LW'(1);
            state <= F_RD;
          end
        end
        default: state <= S_IDLE;
      endcase

      // end of a line and pass stepping
      if (step_q) begin
        if (q == n_m1) begin
          state <= S_LINE;
          if (line_idx == lines_m1) begin
            line_idx <= '0;
            if (!pass_row) begin
              pass_row <= 1'b1;
            end else if (!pass_inside) begin
              pass_row    <= 1'b0;
              pass_inside <= 1'b1;
            end else begin
              fx    <= '0;
              fy    <= '0;
              state <= F_RD;
            end
          end else begin
            line_idx <= line_idx + LW'(1);
          end
        end else begin
          q <= q + LW'(1);
        end
      end
    end
  end

  sdf_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  sdf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  sdf_ram #(.WIDTH(SQ_W), .DEPTH(CELLS)) u_col (
    .clk   (clk),
    .we    (col_we),
    .waddr (line_addr),
    .wdata (sq_wdata),
    .raddr (line_addr),
    .rdata (col_rdata)
  );

  sdf_ram #(.WIDTH(SQ_W), .DEPTH(CELLS)) u_osq (
    .clk   (clk),
    .we    (osq_we),
    .waddr (line_addr),
    .wdata (sq_wdata),
    .raddr (cell_raddr),
    .rdata (osq_rdata)
  );

  sdf_ram #(.WIDTH(SQ_W), .DEPTH(CELLS)) u_isq (
    .clk   (clk),
    .we    (isq_we),
    .waddr (line_addr),
    .wdata (sq_wdata),
    .raddr (cell_raddr),
    .rdata (isq_rdata)
  );

  sdf_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist (
    .clk   (clk),
    .we    (dist_we),
    .waddr (fin_addr),
    .wdata (dist_val),
    .raddr (cell_raddr),
    .rdata (dist_rdata)
  );

  sdf_ram #(.WIDTH($bits(env_entry_t)), .DEPTH(LINE_DEPTH)) u_env (
    .clk   (clk),
    .we    (env_we),
    .waddr (env_waddr),
    .wdata (env_wdata),
    .raddr (env_raddr),
    .rdata (env_rdata)
  );

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == B_DIV || state == F_SQRT))
    else $error("shared unit finished outside a wait state");

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !rsp.busy)
    else $error("shared unit started while busy");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == W_OUT) |-> (k <= top))
    else $error("envelope walk ran past the top entry");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && m_tvalid && !m_tready) |=> (state == S_EMIT))
    else $error("result overwrote a pending transfer");

endmodule

[tb/sv/tb_top.sv]
// testbench of signed_distance_field_2d: grid loads, field computes and cell queries,
// checked against a scoreboard that keeps its own copy of the grid and recomputes the field
// depends on sdf_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_top;
  import sdf_pkg::*;

  typedef struct packed {
    logic signed [31:0] sdist;
    logic [16:0]        outs;
    logic [16:0]        ins;
    logic               oom;
    logic               done;
  } field_result_t;

  class field_scoreboard;
    bit              occ_map[CELLS];
    bit              computed[CELLS];
    int              dist_mem[CELLS];
    bit [16:0]       outs_mem[CELLS];
    bit [16:0]       ins_mem[CELLS];
    longint          col_mem[CELLS];
    longint          lin[LINE_DEPTH];
    longint          lout[LINE_DEPTH];
    longint          sites[LINE_DEPTH];
    longint          bnds[LINE_DEPTH + 1];
    int unsigned     gw = 256, gh = 256, cs = 6554;
    field_result_t   want_q[$];
    int              errors, n_results, n_computes, n_queries, n_oom;

    function int used_w();
      return (gw < 1) ? 1 : (gw > MAX_WIDTH) ? MAX_WIDTH : gw;
    endfunction

    function int used_h();
      return (gh < 1) ? 1 : (gh > MAX_HEIGHT) ? MAX_HEIGHT : gh;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, int unsigned val);
      case (idx)
        REG_GRID_WIDTH:  gw = val & 'h1FF;
        REG_GRID_HEIGHT: gh = val & 'h1FF;
        REG_CELL_SIZE:   cs = val & 'h1FFFFF;
        default: ;
      endcase
    endfunction

    function longint floor_div(longint a, longint b);
      longint qt;
      qt = a / b;
      if ((a % b) != 0 && a < 0) qt--;
      return qt;
    endfunction

    // lower envelope of parabolas over lin[0..n-1]
    function void envelope(int n);
      int top, k;
      longint f, s, v, num, d, val;
      top = -1;
      for (longint q = 0; q < n; q++) begin
        f = lin[q];
        s = 0;
        if (f >= SQ_NONE) continue;
        if (top < 0) begin
          top = 0;
          sites[0] = q;
          continue;
        end
        forever begin
          v = sites[top];
          num = (f + q * q) - (lin[v] + v * v);
          s = floor_div(num, 2 * (q - v));
          if (top > 0 && s <= bnds[top]) begin
            top--;
            continue;
          end
          break;
        end
        top++;
        sites[top] = q;
        bnds[top] = s;
      end
      if (top < 0) begin
        for (int q = 0; q < n; q++) lout[q] = SQ_NONE;
        return;
      end
      k = 0;
      for (longint q = 0; q < n; q++) begin
        while (k < top && bnds[k + 1] < q) k++;
        d = q - sites[k];
        val = d * d + lin[sites[k]];
        lout[q] = (val >= SQ_NONE) ? SQ_NONE : val;
      end
    endfunction

    function void sweep(bit src, int w, int h, bit to_outs);
      for (int x = 0; x < w; x++) begin
        for (int y = 0; y < h; y++)
          lin[y] = (occ_map[y * MAX_WIDTH + x] == src) ? 0 : SQ_NONE;
        envelope(h);
        for (int y = 0; y < h; y++) col_mem[y * MAX_WIDTH + x] = lout[y];
      end
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) lin[x] = col_mem[y * MAX_WIDTH + x];
        envelope(w);
        for (int x = 0; x < w; x++)
          if (to_outs) outs_mem[y * MAX_WIDTH + x] = lout[x];
          else ins_mem[y * MAX_WIDTH + x] = lout[x];
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint meters(longint unsigned d2);
      return (longint'(cs) * int_sqrt(d2 << 16)) >>> 8;
    endfunction

    function void compute_field();
      int w, h, a;
      longint d;
      w = used_w();
      h = used_h();
      sweep(1, w, h, 1);
      sweep(0, w, h, 0);
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          a = y * MAX_WIDTH + x;
          if (occ_map[a])
            d = (ins_mem[a] >= SQ_NONE) ? -64'sd2147483648 : longint'(cs) - meters(ins_mem[a]);
          else
            d = (outs_mem[a] >= SQ_NONE) ? 64'sd2147483647 : meters(outs_mem[a]);
          if (d > 64'sd2147483647) d = 64'sd2147483647;
          if (d < -64'sd2147483648) d = -64'sd2147483648;
          dist_mem[a] = int'(d);
          computed[a] = 1;
        end
    endfunction

    function bit in_grid(int x, int y);
      return x < used_w() && y < used_h();
    endfunction

    function void note_input(logic [1:0] cmd, int x, int y, bit occ);
      field_result_t r;
      int a;
      r = '0;
      a = y * MAX_WIDTH + x;
      case (cmd)
        CMD_CLEAR: foreach (occ_map[i]) occ_map[i] = 0;
        CMD_WRITE: if (in_grid(x, y)) occ_map[a] = occ;
        CMD_COMPUTE: begin
          compute_field();
          r.done = 1;
          want_q.push_back(r);
          n_computes++;
        end
        default: begin
          if (!in_grid(x, y)) begin
            r.oom = 1;
            n_oom++;
          end else begin
            r.sdist = dist_mem[a];
            r.outs = outs_mem[a];
            r.ins = ins_mem[a];
          end
          want_q.push_back(r);
          n_queries++;
        end
      endcase
    endfunction

    function void check(logic [OUT_TDATA_W-1:0] data, logic [1:0] user);
      field_result_t w;
      n_results++;
      if (want_q.size() == 0) begin
        $error("result transfer with no expectation: tdata=%h tuser=%b", data, user);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (data[31:0] !== w.sdist) begin
        $error("signed_distance: expected %0d, got %0d", w.sdist, $signed(data[31:0]));
        errors++;
      end
      if (data[48:32] !== w.outs) begin
        $error("outside_sq: expected %0d, got %0d", w.outs, data[48:32]);
        errors++;
      end
      if (data[65:49] !== w.ins) begin
        $error("inside_sq: expected %0d, got %0d", w.ins, data[65:49]);
        errors++;
      end
      if (user[0] !== w.oom) begin
        $error("out_of_map: expected %0d, got %0d", w.oom, user[0]);
        errors++;
      end
      if (user[1] !== w.done) begin
        $error("compute_done: expected %0d, got %0d", w.done, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [1:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;
  logic                   cfg_we;
  logic [CFG_IW-1:0]      cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  field_scoreboard sb;
  int  n_items;
  bit  last_clear;
  bit  tx_fast, rx_fast;
  bit  hold_go, hold_on;
  int  rx_gap, rx_draw;

  signed_distance_field_2d DUT (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd400_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    hold_on = 0;
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1;
    repeat (600) @(posedge clk);
    hold_on <= 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      rx_gap <= 0;
    end else if (m_tvalid && m_tready) begin
      sb.check(m_tdata, m_tuser);
      rx_draw = rx_fast ? 0 : $urandom_range(0, 18);
      rx_gap <= rx_draw;
      m_tready <= (rx_draw == 0) && !hold_on;
    end else if (hold_on) begin
      m_tready <= 0;
    end else if (rx_gap > 0) begin
      m_tready <= 0;
      rx_gap <= rx_gap - 1;
    end else begin
      m_tready <= 1;
    end
  end

  task automatic send(logic [1:0] cmd, int x, int y, bit occ);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, occ, y[7:0], x[7:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(cmd, x, y, occ);
    n_items++;
    last_clear = (cmd == CMD_CLEAR);
  endtask

  task automatic set_reg(logic [CFG_IW-1:0] idx, int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val[CFG_W-1:0]);
  endtask

  // all results in and any trailing write or clear finished
  task automatic settle();
    s_tvalid <= 0;
    do @(posedge clk); while (sb.want_q.size() != 0);
    repeat (last_clear ? 70000 : 100) @(posedge clk);
  endtask

  task automatic set_grid(int w, int h, int unsigned c);
    settle();
    set_reg(REG_GRID_WIDTH, w);
    set_reg(REG_GRID_HEIGHT, h);
    set_reg(REG_CELL_SIZE, c);
  endtask

  task automatic query_some();
    int x, y, uw, uh;
    uw = sb.used_w();
    uh = sb.used_h();
    x = $urandom_range(0, uw - 1);
    y = $urandom_range(0, uh - 1);
    if ($urandom_range(0, 7) == 0 || !sb.computed[y * MAX_WIDTH + x]) begin
      if (uw < 256 && (uh == 256 || $urandom_range(0, 1))) begin
        x = $urandom_range(uw, 255);
        y = $urandom_range(0, 255);
      end else begin
        x = $urandom_range(0, 255);
        y = $urandom_range(uh, 255);
      end
    end
    send(CMD_QUERY, x, y, $urandom_range(0, 1));
  endtask

  task automatic run_phase(int w, int h, int unsigned c, bit clr);
    int uw, uh, pct, nq;
    set_grid(w, h, c);
    if (clr) send(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), 1);
    uw = sb.used_w();
    uh = sb.used_h();
    pct = $urandom_range(0, 3) == 0 ? 100 * $urandom_range(0, 1) : $urandom_range(5, 60);
    if (uw * uh <= 100) begin
      for (int y = 0; y < uh; y++)
        for (int x = 0; x < uw; x++)
          send(CMD_WRITE, x, y, $urandom_range(1, 100) <= pct);
    end else begin
      repeat (40)
        send(CMD_WRITE, $urandom_range(0, uw - 1), $urandom_range(0, uh - 1),
             $urandom_range(1, 100) <= pct);
    end
    repeat (3) send(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 1));
    send(CMD_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
    nq = $urandom_range(15, 40);
    repeat (nq) query_some();
    repeat (2) send(CMD_WRITE, $urandom_range(0, uw - 1), $urandom_range(0, uh - 1),
                    $urandom_range(0, 1));
    repeat (5) query_some();
  endtask

  initial begin
    int k, w, h, n_clears;
    int unsigned c;
    sb = new();
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = CMD_CLEAR;
    cfg_we = 0;
    cfg_index = REG_GRID_WIDTH;
    cfg_wdata = '0;
    tx_fast = 0;
    rx_fast = 0;
    hold_go = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty map, full map, stale reads, off-grid access, clear
    set_reg(REG_GRID_WIDTH, 2);
    set_reg(REG_GRID_HEIGHT, 2);
    set_reg(REG_CELL_SIZE, 65536);
    for (int i = 0; i < 4; i++) send(CMD_WRITE, i % 2, i / 2, 0);
    send(CMD_COMPUTE, 0, 0, 0);
    send(CMD_QUERY, 0, 0, 0);
    send(CMD_QUERY, 255, 255, 1);
    send(CMD_WRITE, 1, 1, 1);
    send(CMD_WRITE, 200, 3, 1);
    send(CMD_QUERY, 1, 1, 0);
    send(CMD_COMPUTE, 0, 0, 0);
    send(CMD_QUERY, 0, 0, 0);
    send(CMD_QUERY, 1, 1, 0);
    for (int i = 0; i < 4; i++) send(CMD_WRITE, i % 2, i / 2, 1);
    send(CMD_COMPUTE, 255, 255, 1);
    send(CMD_QUERY, 0, 1, 0);
    send(CMD_QUERY, 2, 0, 0);
    send(CMD_CLEAR, 0, 0, 0);
    send(CMD_COMPUTE, 0, 0, 0);
    send(CMD_QUERY, 1, 0, 0);
    send(CMD_QUERY, 0, 2, 0);

    k = 0;
    n_clears = 1;
    while (n_items < 1125) begin
      tx_fast = (k % 4 == 1);
      rx_fast = (k % 5 == 2);
      case (k)
        0: begin w = 511; h = 1; c = 1; end
        1: begin w = 1; h = 511; c = 1048576; end
        2: begin w = 0; h = 0; c = 2097151; end
        3: begin w = 256; h = 2; c = 6554; end
        4: begin w = 3; h = 256; c = 1; end
        default: begin
          w = $urandom_range(0, 5) == 0 ? $urandom_range(0, 14) : $urandom_range(1, 9);
          h = $urandom_range(0, 5) == 0 ? $urandom_range(0, 14) : $urandom_range(1, 9);
          c = $urandom_range(0, 3) == 0 ? 1 << $urandom_range(0, 20) : $urandom_range(1, 2097151);
        end
      endcase
      if (k == 6) begin
        tx_fast = 1;
        hold_go = 1;
      end
      run_phase(w, h, c, (k % 7 == 5) && n_clears < 4);
      if (k % 7 == 5) n_clears++;
      k++;
    end

    settle();
    $display("%0d input transfers, %0d results (%0d computes, %0d queries, %0d off grid)",
             n_items, sb.n_results, sb.n_computes, sb.n_queries, sb.n_oom);
    $display("grid sizes from 1x1 to 256 wide or tall, cell sizes 1 to 2097151, %0d phases", k);
    if (sb.errors == 0 && sb.want_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/core/sdf_pkg.sv
rtl/core/sdf_ram.sv
rtl/core/sdf_iter_unit.sv
rtl/core/signed_distance_field_2d.sv
tb/sv/tb_top.sv
